### design/mask_outline_3x3_macros.svh
// Assertion macros used by the mask outline checker.
`ifndef MASK_OUTLINE_3X3_MACROS_SVH
`define MASK_OUTLINE_3X3_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define MOL_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("mask_outline_3x3: check failed");

// Next-cycle implication, off while reset is held.
`define MOL_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("mask_outline_3x3: check failed");

// What must hold in the cycle after each cycle in which reset is held.
`define MOL_ASSERT_RST(lbl, clk, rstn, cons) \
    lbl: assert property (@(posedge clk) !(rstn) |=> (cons)) \
        else $error("mask_outline_3x3: reset check failed");

`endif

### design/mol_pkg.sv
// Shared types and constants of the mask outline block.
`timescale 1ns / 1ps

package mol_pkg;

    localparam int CFG_W_BITS = 13;
    localparam int CFG_H_BITS = 16;
    localparam int MASK_BITS  = 8;
    localparam int OUT_X_BITS = 12;
    localparam int OUT_Y_BITS = 16;
    localparam int PIX_BITS   = 8;
    localparam int TDATA_BITS = 40;
    localparam int SEL_BIT    = 7;

    localparam logic [PIX_BITS-1:0]   PIX_OUTLINE = 8'h00;
    localparam logic [PIX_BITS-1:0]   PIX_WHITE   = 8'hFF;
    localparam logic [CFG_W_BITS-1:0] WIDTH_RESET  = 13'd1024;
    localparam logic [CFG_H_BITS-1:0] HEIGHT_RESET = 16'd1024;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_CW    = 3;

    typedef struct packed {
        logic                  last;
        logic [PIX_BITS-1:0]   pixel;
        logic [OUT_Y_BITS-1:0] y;
        logic [OUT_X_BITS-1:0] x;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result item;
    } t_push;

    typedef struct packed {
        logic [CFG_W_BITS-1:0] width;
        logic [CFG_H_BITS-1:0] height;
        logic                  restart;
    } t_cfg;

endpackage

### design/mol_front.sv
// Front part: raster counters, line store, 3x3 window and outline classification.
`timescale 1ns / 1ps

module mol_front
    import mol_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  logic                 i_tvalid,
    output logic                 o_tready,
    input  logic [MASK_BITS-1:0] i_mask_value,
    input  logic [Q_CW-1:0]      i_q_count,
    output t_push                o_push
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int EW = (AW + 1 > CFG_W_BITS) ? AW + 1 : CFG_W_BITS;
    localparam logic [EW-1:0] W_MAX = EW'(MAX_WIDTH);

    logic [AW-1:0]         r_x;
    logic [CFG_H_BITS-1:0] r_y;

    logic                  r_s1_valid;
    logic [AW-1:0]         r_s1_x;
    logic [CFG_H_BITS-1:0] r_s1_y;
    logic                  r_s1_cur;
    logic                  r_s1_last;
    logic                  r_s1_emit;

    logic [1:0]            r_line [MAX_WIDTH];
    logic [1:0]            r_rd;
    logic                  r_fwd;
    logic [1:0]            r_fwd_data;
    logic [5:0]            r_win;

    logic [EW-1:0]         w_raw;
    logic [EW-1:0]         w_eff;
    logic [CFG_H_BITS:0]   h_eff;
    logic                  last_col;
    logic                  last_row;
    logic                  accept;
    logic [1:0]            rd_data;
    logic [1:0]            wr_data;
    logic [2:0]            col;
    logic                  all_set;

    assign w_raw = EW'(i_cfg.width);
    assign w_eff = (w_raw == '0) ? EW'(1) : ((w_raw > W_MAX) ? W_MAX : w_raw);
    assign h_eff = (i_cfg.height == '0) ? (CFG_H_BITS+1)'(1) : {1'b0, i_cfg.height};

    assign last_col = (EW'(r_x) + EW'(1)) >= w_eff;
    assign last_row = ({1'b0, r_y} + (CFG_H_BITS+1)'(1)) >= h_eff;

    assign o_tready = (i_q_count + Q_CW'(r_s1_valid)) < Q_CW'(Q_DEPTH);
    assign accept   = i_tvalid && o_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg.restart) begin
            r_x <= '0;
            r_y <= '0;
        end else if (accept) begin
            if (last_col) begin
                r_x <= '0;
                r_y <= last_row ? '0 : r_y + CFG_H_BITS'(1);
            end else begin
                r_x <= r_x + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            r_fwd      <= accept && r_s1_valid && (r_x == r_s1_x);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_x    <= r_x;
            r_s1_y    <= r_y;
            r_s1_cur  <= i_mask_value[SEL_BIT];
            r_s1_last <= last_col && last_row;
            r_s1_emit <= (r_x >= AW'(2)) && (r_y >= CFG_H_BITS'(2));
        end
        r_fwd_data <= wr_data;
    end

    // bit 0: two rows above, bit 1: row above
    assign rd_data = r_fwd ? r_fwd_data : r_rd;
    assign wr_data = {r_s1_cur, rd_data[1]};
    assign col     = {r_s1_cur, rd_data[1], rd_data[0]};

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd <= r_line[r_x];
        end
        if (r_s1_valid) begin
            r_line[r_s1_x] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg.restart) begin
            r_win <= '0;
        end else if (r_s1_valid) begin
            r_win <= {r_win[2:0], col};
        end
    end

    assign all_set = (col == 3'b111) && (r_win[5:3] == 3'b111) && r_win[2] && r_win[0];

    always_comb begin
        o_push.valid      = r_s1_valid && r_s1_emit;
        o_push.item.x     = OUT_X_BITS'(r_s1_x - AW'(1));
        o_push.item.y     = r_s1_y - CFG_H_BITS'(1);
        o_push.item.pixel = (r_win[1] && !all_set) ? PIX_OUTLINE : PIX_WHITE;
        o_push.item.last  = r_s1_last;
    end

endmodule

### design/mol_queue.sv
// Back part: short result queue and the registered output stage.
`timescale 1ns / 1ps

module mol_queue
    import mol_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_push           i_push,
    input  logic            i_tready,
    output logic            o_tvalid,
    output t_result         o_item,
    output logic [Q_CW-1:0] o_count
);

    t_result         r_q [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_CW-1:0] r_count;
    logic [Q_CW-1:0] n_count;
    logic            r_out_valid;
    t_result         r_out;
    logic            pop;

    assign pop     = (r_count != '0) && (!r_out_valid || i_tready);
    assign n_count = r_count + Q_CW'(i_push.valid) - Q_CW'(pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_rp        <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_push.valid) begin
                r_wp <= r_wp + Q_AW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + Q_AW'(1);
            end
            if (!r_out_valid || i_tready) begin
                r_out_valid <= (r_count != '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_q[r_wp] <= i_push.item;
        end
        if (pop) begin
            r_out <= r_q[r_rp];
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_item   = r_out;
    assign o_count  = r_count;

endmodule

### design/mask_outline_3x3.sv
// Top level of the streaming 3x3 mask outline block.
`timescale 1ns / 1ps
// Input stream s_axis: one selection mask byte per transfer in raster order; only
// bit 7 counts. Output stream m_axis: one transfer per interior pixel, carrying its
// column, row and value (0 on the outline, 255 elsewhere); tlast marks the last
// interior pixel of the frame. Border rows and columns give no transfer.
// APB port: frame_width at 0x0, frame_height at 0x4. A write restarts the frame;
// write only while the block is idle.
// Throughput: one pixel per cycle while s_axis_tready is high, set by the line store,
// which takes one read and one write per pixel. A result passes the first stage register,
// then the result queue and then the output register before it is shown on m_axis.
// A result queue of four entries sits before the output register; s_axis_tready
// drops only when the queue and the stage feeding it would be full, so a stalled
// receiver backs pressure up to the input, and nothing is lost.
// Reset clears counters, window, queue and output stage and restores 1024x1024.
// The line store is not cleared; the first two rows of a frame fill it.
module mask_outline_3x3
    import mol_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [MASK_BITS-1:0]  s_axis_tdata,   // [7:0] mask_value
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [TDATA_BITS-1:0] m_axis_tdata,   // [11:0] out_x, [27:12] out_y, [35:28] out_pixel
    output logic                  m_axis_tlast,   // frame_last
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [CFG_W_BITS-1:0] r_width;
    logic [CFG_H_BITS-1:0] r_height;
    logic                  cfg_wr;
    t_cfg                  cfg;
    t_push                 push;
    t_result               item;
    logic [Q_CW-1:0]       q_count;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_WIDTH:  r_width  <= pwdata[CFG_W_BITS-1:0];
                REG_HEIGHT: r_height <= pwdata[CFG_H_BITS-1:0];
                default:    r_width  <= r_width;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_WIDTH:  prdata = {{(32-CFG_W_BITS){1'b0}}, r_width};
            REG_HEIGHT: prdata = {{(32-CFG_H_BITS){1'b0}}, r_height};
            default:    prdata = '0;
        endcase
    end

    always_comb begin
        cfg.width   = r_width;
        cfg.height  = r_height;
        cfg.restart = cfg_wr;
    end

    mol_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_tvalid     (s_axis_tvalid),
        .o_tready     (s_axis_tready),
        .i_mask_value (s_axis_tdata),
        .i_q_count    (q_count),
        .o_push       (push)
    );

    mol_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_tready (m_axis_tready),
        .o_tvalid (m_axis_tvalid),
        .o_item   (item),
        .o_count  (q_count)
    );

    assign m_axis_tdata = {{(TDATA_BITS-OUT_X_BITS-OUT_Y_BITS-PIX_BITS){1'b0}},
                           item.pixel, item.y, item.x};
    assign m_axis_tlast = item.last;

endmodule

### design/mol_checker.sv
// Port-level checks of the mask outline block and their binding to the top level.
`timescale 1ns / 1ps
`include "mask_outline_3x3_macros.svh"

module mol_checker
    import mol_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [TDATA_BITS-1:0] m_axis_tdata,
    input logic                  m_axis_tlast
);

    logic                  out_wait;
    logic [OUT_Y_BITS-1:0] out_y;
    logic [PIX_BITS-1:0]   out_pix;
    logic [3:0]            out_pad;
    logic                  out_form_ok;

    assign out_wait    = m_axis_tvalid && !m_axis_tready;
    assign out_y       = m_axis_tdata[27:12];
    assign out_pix     = m_axis_tdata[35:28];
    assign out_pad     = m_axis_tdata[39:36];
    assign out_form_ok = (out_y != '0) && (out_pad == '0) &&
                         (out_pix == PIX_OUTLINE || out_pix == PIX_WHITE);

    `MOL_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_wait, m_axis_tvalid)
    `MOL_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, out_wait, $stable({m_axis_tlast, m_axis_tdata}))
    `MOL_ASSERT_RST(a_rst_empty, i_clk, i_rst_n, !m_axis_tvalid)
    `MOL_ASSERT_IMP(a_out_form, i_clk, i_rst_n, m_axis_tvalid, out_form_ok)

endmodule

bind mask_outline_3x3 mol_checker u_mol_checker (.*);
